// ===== sv/fhpc_pkg.sv =====
// Shared types, constants and lookup functions for the frame header classifier.
`default_nettype none
package fhpc_pkg;

  typedef enum logic [3:0] {
    ETH_CLASS_UNKNOWN  = 4'd0,
    ETH_CLASS_IPV4     = 4'd1,
    ETH_CLASS_ARP      = 4'd2,
    ETH_CLASS_IPV6     = 4'd3,
    ETH_CLASS_X75      = 4'd4,
    ETH_CLASS_PUP      = 4'd5,
    ETH_CLASS_RARP     = 4'd6,
    ETH_CLASS_MPLS_UNI = 4'd7,
    ETH_CLASS_MPLS_MC  = 4'd8,
    ETH_CLASS_SPECIAL  = 4'd9
  } ether_class_e;

  typedef enum logic [1:0] {
    L4_NONE = 2'd0,
    L4_TCP  = 2'd1,
    L4_UDP  = 2'd2
  } l4_kind_e;

  typedef enum logic [3:0] {
    APP_NONE  = 4'd0,
    APP_HTTP  = 4'd1,
    APP_HTTPS = 4'd2,
    APP_FTP   = 4'd3,
    APP_SMTP  = 4'd4,
    APP_SSH   = 4'd5,
    APP_SIP   = 4'd6,
    APP_DNS   = 4'd7,
    APP_DHCP  = 4'd8,
    APP_TFTP  = 4'd9,
    APP_SNMP  = 4'd10,
    APP_RIP   = 4'd11
  } app_class_e;

  localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
  localparam logic [15:0] ETYPE_ARP      = 16'h0806;
  localparam logic [15:0] ETYPE_IPV6     = 16'h86DD;
  localparam logic [15:0] ETYPE_X75      = 16'h0801;
  localparam logic [15:0] ETYPE_PUP      = 16'h0805;
  localparam logic [15:0] ETYPE_RARP     = 16'h8035;
  localparam logic [15:0] ETYPE_MPLS_UNI = 16'h8847;
  localparam logic [15:0] ETYPE_MPLS_MC  = 16'h8848;
  localparam logic [15:0] ETYPE_SPECIAL  = 16'h9000;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [7:0] TLS_HANDSHAKE = 8'h16;

  localparam logic [15:0] PORT_FTP   = 16'd21;
  localparam logic [15:0] PORT_SSH   = 16'd22;
  localparam logic [15:0] PORT_SMTP  = 16'd25;
  localparam logic [15:0] PORT_DNS   = 16'd53;
  localparam logic [15:0] PORT_DHCPS = 16'd67;
  localparam logic [15:0] PORT_DHCPC = 16'd68;
  localparam logic [15:0] PORT_TFTP  = 16'd69;
  localparam logic [15:0] PORT_HTTP  = 16'd80;
  localparam logic [15:0] PORT_SNMP  = 16'd161;
  localparam logic [15:0] PORT_HTTPS = 16'd443;
  localparam logic [15:0] PORT_RIP   = 16'd520;
  localparam logic [15:0] PORT_SIP   = 16'd5060;

  localparam int unsigned NUM_PREFIXES   = 8;
  localparam int unsigned PREFIX_MAX_LEN = 10;

  // Prefix bits: USER, PASS, EHLO, MAIL FROM:, RCPT TO:, DATA, SSH-, SIP
  localparam int unsigned PFX_USER = 0;
  localparam int unsigned PFX_PASS = 1;
  localparam int unsigned PFX_EHLO = 2;
  localparam int unsigned PFX_MAIL = 3;
  localparam int unsigned PFX_RCPT = 4;
  localparam int unsigned PFX_DATA = 5;
  localparam int unsigned PFX_SSH  = 6;
  localparam int unsigned PFX_SIP  = 7;

  localparam logic [7:0] PREFIX_TEXT [NUM_PREFIXES][PREFIX_MAX_LEN] = '{
    '{8'h55, 8'h53, 8'h45, 8'h52, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h41, 8'h53, 8'h53, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h45, 8'h48, 8'h4C, 8'h4F, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4D, 8'h41, 8'h49, 8'h4C, 8'h20, 8'h46, 8'h52, 8'h4F, 8'h4D, 8'h3A},
    '{8'h52, 8'h43, 8'h50, 8'h54, 8'h20, 8'h54, 8'h4F, 8'h3A, 8'h00, 8'h00},
    '{8'h44, 8'h41, 8'h54, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h53, 8'h53, 8'h48, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h53, 8'h49, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] PREFIX_LEN [NUM_PREFIXES] = '{
    4'd5, 4'd5, 4'd5, 4'd10, 4'd8, 4'd4, 4'd4, 4'd3
  };

  function automatic ether_class_e class_of_type(input logic [15:0] t);
    ether_class_e c;
    unique case (t)
      ETYPE_IPV4:     c = ETH_CLASS_IPV4;
      ETYPE_ARP:      c = ETH_CLASS_ARP;
      ETYPE_IPV6:     c = ETH_CLASS_IPV6;
      ETYPE_X75:      c = ETH_CLASS_X75;
      ETYPE_PUP:      c = ETH_CLASS_PUP;
      ETYPE_RARP:     c = ETH_CLASS_RARP;
      ETYPE_MPLS_UNI: c = ETH_CLASS_MPLS_UNI;
      ETYPE_MPLS_MC:  c = ETH_CLASS_MPLS_MC;
      ETYPE_SPECIAL:  c = ETH_CLASS_SPECIAL;
      default:        c = ETH_CLASS_UNKNOWN;
    endcase
    return c;
  endfunction

  function automatic logic proto_in_table(input logic [7:0] p);
    logic k;
    if (p <= 8'd33) begin
      k = 1'b1;
    end else begin
      unique case (p)
        8'd41, 8'd43, 8'd44, 8'd46, 8'd47, 8'd50, 8'd51,
        8'd60, 8'd67, 8'd68, 8'd89, 8'd128, 8'd253, 8'd254: k = 1'b1;
        default: k = 1'b0;
      endcase
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== sv/fhpc_in_if.sv =====
// Frame byte channel: valid/ready handshake with byte and end-of-frame mark.
`default_nettype none
interface fhpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== sv/fhpc_out_if.sv =====
// Classification result channel: valid/ready handshake with per-frame result fields.
`default_nettype none
interface fhpc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] eth_type;
  logic [3:0]  ether_class;
  logic [7:0]  ipv4_proto;
  logic        protocol_known;
  logic [1:0]  l4_kind;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [7:0]  tcp_flag_bits;
  logic [3:0]  app_class;
  logic        truncated;

  modport source (
    output valid, input ready,
    output eth_type, output ether_class, output ipv4_proto, output protocol_known,
    output l4_kind, output source_port, output dest_port, output tcp_flag_bits,
    output app_class, output truncated
  );
  modport sink (
    input valid, output ready,
    input eth_type, input ether_class, input ipv4_proto, input protocol_known,
    input l4_kind, input source_port, input dest_port, input tcp_flag_bits,
    input app_class, input truncated
  );
endinterface
`default_nettype wire

// ===== sv/frame_header_protocol_classifier_core.sv =====
// Top level: per-byte Ethernet/IPv4/L4 header parser and per-frame classifier.
//
// Usage:
//   in_i carries one frame byte per transaction, wire order, last_byte set on the
//   final byte. out_o carries one result transaction per frame: ethertype and
//   class, IPv4 protocol, L4 kind, ports, TCP flags, application class and a
//   truncated flag.
//   Throughput: one byte per cycle while in_i.ready is high, with no gap needed
//   between frames. The parse state is updated at each byte; once the last
//   byte is taken and the output stage is free, the result is built from the
//   parse state and registered in the output stage, raising out_o.valid.
//   Stall: a held result in the output stage does not stop byte intake. Only
//   when a finished frame waits for that stage while it is still full does
//   in_i.ready drop, until out_o is taken.
//   Reset: all parse state returns to its idle values, no result is pending.
//   Bytes beyond MAX_FRAME_BYTES are dropped until the end-of-frame mark.
`default_nettype none
module frame_header_protocol_classifier_core
  import fhpc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 16383
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fhpc_in_if.sink     in_i,
  fhpc_out_if.source  out_o
);

  localparam int unsigned OFF_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned CW    = ((OFF_W > 8) ? OFF_W : 8) + 1;
  localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_FRAME_BYTES);

  // parse state
  logic [OFF_W-1:0] offset_q, offset_d;
  logic [3:0]       ihl_q, ihl_d;
  logic [3:0]       tcp_words_q, tcp_words_d;
  logic [15:0]      etype_q, etype_d;
  logic [7:0]       proto_q, proto_d;
  logic [15:0]      sport_q, sport_d;
  logic [15:0]      dport_q, dport_d;
  logic [7:0]       flags_q, flags_d;
  logic [OFF_W-1:0] pcount_q, pcount_d;
  logic [7:0]       pmatch_q, pmatch_d;
  logic [7:0]       first_q, first_d;

  logic pend_q, pend_d;
  logic out_valid_q;
  logic slot_free, in_fire, state_en, finish_now;

  assign slot_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = !(pend_q && !slot_free);
  assign in_fire    = in_i.valid && in_i.ready;
  assign finish_now = pend_q && slot_free;
  assign state_en   = in_fire || finish_now;
  assign pend_d     = in_fire && in_i.last_byte;

  // per-byte update, starting from idle state when the previous frame closes
  always_comb begin
    logic [OFF_W-1:0] p;
    logic [7:0]       b;
    logic [CW-1:0]    p_ext, l4_ext, rel, start, k;
    logic             in_l4, pay;
    p      = pend_q ? '0 : offset_q;
    ihl_d       = pend_q ? '0 : ihl_q;
    tcp_words_d = pend_q ? '0 : tcp_words_q;
    etype_d     = pend_q ? '0 : etype_q;
    proto_d     = pend_q ? '0 : proto_q;
    sport_d     = pend_q ? '0 : sport_q;
    dport_d     = pend_q ? '0 : dport_q;
    flags_d     = pend_q ? '0 : flags_q;
    pcount_d    = pend_q ? '0 : pcount_q;
    pmatch_d    = pend_q ? '1 : pmatch_q;
    first_d     = pend_q ? '0 : first_q;
    offset_d    = p;
    b      = in_i.frame_byte;
    p_ext  = CW'(p);
    l4_ext = CW'(14) + CW'({ihl_d, 2'b00});
    rel    = p_ext - l4_ext;
    in_l4  = (ihl_d != 4'd0) && (p_ext >= CW'(24)) && (p_ext >= l4_ext);
    start  = (proto_d == PROTO_TCP) ? CW'({tcp_words_d, 2'b00}) : CW'(8);
    pay    = in_l4 && (rel >= start) &&
             ((proto_d == PROTO_UDP) ||
              ((proto_d == PROTO_TCP) && (tcp_words_d != 4'd0)));
    k      = rel - start;

    if (in_fire && (p < OFF_MAX)) begin
      offset_d = p + OFF_W'(1);
      if (p == OFF_W'(12)) etype_d[15:8] = b;
      if (p == OFF_W'(13)) etype_d[7:0]  = b;
      if (p == OFF_W'(14)) ihl_d = (b[3:0] < 4'd5) ? 4'd5 : b[3:0];
      if (p == OFF_W'(23)) proto_d = b;
      if (in_l4) begin
        if (rel == CW'(0)) sport_d[15:8] = b;
        if (rel == CW'(1)) sport_d[7:0]  = b;
        if (rel == CW'(2)) dport_d[15:8] = b;
        if (rel == CW'(3)) dport_d[7:0]  = b;
        if (proto_d == PROTO_TCP) begin
          if (rel == CW'(12)) tcp_words_d = (b[7:4] < 4'd5) ? 4'd5 : b[7:4];
          if (rel == CW'(13)) flags_d = b;
        end
      end
      if (pay) begin
        if (k == CW'(0)) first_d = b;
        if (k < CW'(PREFIX_MAX_LEN)) begin
          for (int i = 0; i < NUM_PREFIXES; i++) begin
            if ((k[3:0] < PREFIX_LEN[i]) && (PREFIX_TEXT[i][k[3:0]] != b)) begin
              pmatch_d[i] = 1'b0;
            end
          end
        end
        if (pcount_d < OFF_MAX) pcount_d = pcount_d + OFF_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      ihl_q       <= '0;
      tcp_words_q <= '0;
      etype_q     <= '0;
      proto_q     <= '0;
      sport_q     <= '0;
      dport_q     <= '0;
      flags_q     <= '0;
      pcount_q    <= '0;
      pmatch_q    <= '1;
      first_q     <= '0;
      pend_q      <= 1'b0;
    end else if (state_en) begin
      offset_q    <= offset_d;
      ihl_q       <= ihl_d;
      tcp_words_q <= tcp_words_d;
      etype_q     <= etype_d;
      proto_q     <= proto_d;
      sport_q     <= sport_d;
      dport_q     <= dport_d;
      flags_q     <= flags_d;
      pcount_q    <= pcount_d;
      pmatch_q    <= pmatch_d;
      first_q     <= first_d;
      pend_q      <= pend_d;
    end
  end

  // end-of-frame result from the parse state
  logic [15:0]  r_et, r_sp, r_dp;
  ether_class_e r_ec;
  logic [7:0]   r_pr, r_fl;
  logic         r_known, r_trunc;
  l4_kind_e     r_kind;
  app_class_e   r_app;

  always_comb begin
    logic [CW-1:0] n, l4;
    logic [7:0]    hp;
    n  = CW'(offset_q);
    l4 = CW'(14) + CW'({ihl_q, 2'b00});
    for (int i = 0; i < NUM_PREFIXES; i++) begin
      hp[i] = pmatch_q[i] && (pcount_q >= OFF_W'(PREFIX_LEN[i]));
    end
    r_et = '0; r_ec = ETH_CLASS_UNKNOWN; r_pr = '0; r_known = 1'b0; r_kind = L4_NONE;
    r_sp = '0; r_dp = '0; r_fl = '0; r_app = APP_NONE; r_trunc = 1'b0;
    if (n >= CW'(14)) begin
      r_et = etype_q;
      r_ec = class_of_type(etype_q);
    end
    if (n >= CW'(24)) begin
      r_pr    = proto_q;
      r_known = proto_in_table(proto_q);
      r_kind  = (proto_q == PROTO_TCP) ? L4_TCP :
                (proto_q == PROTO_UDP) ? L4_UDP : L4_NONE;
    end
    if ((n < CW'(15)) || (ihl_q == 4'd0)) begin
      r_trunc = 1'b1;
    end else begin
      if (n < l4) r_trunc = 1'b1;
      if ((r_kind != L4_NONE) && (n >= l4 + CW'(4))) begin
        r_sp = sport_q;
        r_dp = dport_q;
      end
      if (r_kind == L4_TCP) begin
        if (n >= l4 + CW'(14)) r_fl = flags_q;
        if ((tcp_words_q == 4'd0) || (n < l4 + CW'({tcp_words_q, 2'b00}))) r_trunc = 1'b1;
      end else if (r_kind == L4_UDP) begin
        if (n < l4 + CW'(8)) r_trunc = 1'b1;
      end
    end
    if (pcount_q != '0) begin
      if (r_kind == L4_TCP) begin
        priority if (r_sp == PORT_HTTP || r_dp == PORT_HTTP) begin
          r_app = APP_HTTP;
        end else if (r_sp == PORT_HTTPS || r_dp == PORT_HTTPS) begin
          r_app = ((pcount_q > OFF_W'(5)) && (first_q == TLS_HANDSHAKE)) ? APP_HTTPS : APP_HTTP;
        end else if ((r_sp == PORT_FTP || r_dp == PORT_FTP) &&
                     (hp[PFX_USER] || hp[PFX_PASS])) begin
          r_app = APP_FTP;
        end else if ((r_sp == PORT_SMTP || r_dp == PORT_SMTP) &&
                     (hp[PFX_EHLO] || hp[PFX_MAIL] || hp[PFX_RCPT] || hp[PFX_DATA])) begin
          r_app = APP_SMTP;
        end else if ((r_sp == PORT_SSH || r_dp == PORT_SSH) && hp[PFX_SSH]) begin
          r_app = APP_SSH;
        end else if ((r_sp == PORT_SIP || r_dp == PORT_SIP) && hp[PFX_SIP]) begin
          r_app = APP_SIP;
        end else begin
          r_app = APP_NONE;
        end
      end else if (r_kind == L4_UDP) begin
        priority if (r_sp == PORT_DNS || r_dp == PORT_DNS) begin
          r_app = APP_DNS;
        end else if (r_sp == PORT_DHCPS || r_dp == PORT_DHCPS ||
                     r_sp == PORT_DHCPC || r_dp == PORT_DHCPC) begin
          r_app = APP_DHCP;
        end else if (r_sp == PORT_TFTP || r_dp == PORT_TFTP) begin
          r_app = APP_TFTP;
        end else if (r_sp == PORT_SNMP || r_dp == PORT_SNMP) begin
          r_app = APP_SNMP;
        end else if (r_sp == PORT_RIP || r_dp == PORT_RIP) begin
          r_app = APP_RIP;
        end else begin
          r_app = APP_NONE;
        end
      end
    end
  end

  // output stage
  logic [15:0] o_et_q, o_sp_q, o_dp_q;
  logic [3:0]  o_ec_q, o_app_q;
  logic [7:0]  o_pr_q, o_fl_q;
  logic [1:0]  o_kind_q;
  logic        o_known_q, o_trunc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish_now) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish_now) begin
      o_et_q    <= r_et;
      o_ec_q    <= r_ec;
      o_pr_q    <= r_pr;
      o_known_q <= r_known;
      o_kind_q  <= r_kind;
      o_sp_q    <= r_sp;
      o_dp_q    <= r_dp;
      o_fl_q    <= r_fl;
      o_app_q   <= r_app;
      o_trunc_q <= r_trunc;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.eth_type       = o_et_q;
  assign out_o.ether_class    = o_ec_q;
  assign out_o.ipv4_proto     = o_pr_q;
  assign out_o.protocol_known = o_known_q;
  assign out_o.l4_kind        = o_kind_q;
  assign out_o.source_port    = o_sp_q;
  assign out_o.dest_port      = o_dp_q;
  assign out_o.tcp_flag_bits  = o_fl_q;
  assign out_o.app_class      = o_app_q;
  assign out_o.truncated      = o_trunc_q;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the frame header protocol classifier core.
`timescale 1ns / 100ps
module tb_top;
  import fhpc_pkg::*;

  localparam int unsigned MAX_BYTES = 128;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned BYTE_TARGET = 1750;
  localparam int unsigned FRAME_TARGET = 6;

  typedef struct {
    logic [15:0]  eth_type;
    ether_class_e ether_class;
    logic [7:0]   ipv4_proto;
    logic         protocol_known;
    l4_kind_e     l4_kind;
    logic [15:0]  source_port;
    logic [15:0]  dest_port;
    logic [7:0]   tcp_flag_bits;
    app_class_e   app_class;
    logic         truncated;
  } frame_verdict_t;

  class frame_verdict_board;
    string          pfx_text[NUM_PREFIXES];
    bit [13:0]      offs;
    bit [3:0]       ihl_w;
    bit [3:0]       tcp_w;
    bit [63:0]      cap;
    bit [13:0]      pay_n;
    bit [7:0]       pfx_ok;
    bit [7:0]       first_pay;
    frame_verdict_t verdict_q[$];
    int unsigned    errors;

    function new();
      pfx_text = '{"USER ", "PASS ", "EHLO ", "MAIL FROM:", "RCPT TO:", "DATA", "SSH-", "SIP"};
      errors = 0;
      clear();
    endfunction

    function void clear();
      offs = '0;
      ihl_w = '0;
      tcp_w = '0;
      cap = '0;
      pay_n = '0;
      pfx_ok = 8'hFF;
      first_pay = '0;
    endfunction

    function bit has_pfx(int unsigned i);
      return pfx_ok[i] && (pay_n >= pfx_text[i].len());
    endfunction

    function bit on_port(bit [15:0] s, bit [15:0] d, bit [15:0] p);
      return (s == p) || (d == p);
    endfunction

    function ether_class_e ether_class_for(bit [15:0] t);
      case (t)
        ETYPE_IPV4:     return ETH_CLASS_IPV4;
        ETYPE_ARP:      return ETH_CLASS_ARP;
        ETYPE_IPV6:     return ETH_CLASS_IPV6;
        ETYPE_X75:      return ETH_CLASS_X75;
        ETYPE_PUP:      return ETH_CLASS_PUP;
        ETYPE_RARP:     return ETH_CLASS_RARP;
        ETYPE_MPLS_UNI: return ETH_CLASS_MPLS_UNI;
        ETYPE_MPLS_MC:  return ETH_CLASS_MPLS_MC;
        ETYPE_SPECIAL:  return ETH_CLASS_SPECIAL;
        default:        return ETH_CLASS_UNKNOWN;
      endcase
    endfunction

    function bit proto_named(bit [7:0] p);
      if (p <= 8'd33) return 1'b1;
      case (p)
        8'd41, 8'd43, 8'd44, 8'd46, 8'd47, 8'd50, 8'd51,
        8'd60, 8'd67, 8'd68, 8'd89, 8'd128, 8'd253, 8'd254: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function app_class_e tcp_app(bit [15:0] s, bit [15:0] d);
      if (on_port(s, d, PORT_HTTP)) return APP_HTTP;
      if (on_port(s, d, PORT_HTTPS))
        return (pay_n > 5 && first_pay == TLS_HANDSHAKE) ? APP_HTTPS : APP_HTTP;
      if (on_port(s, d, PORT_FTP) && (has_pfx(PFX_USER) || has_pfx(PFX_PASS))) return APP_FTP;
      if (on_port(s, d, PORT_SMTP) && (has_pfx(PFX_EHLO) || has_pfx(PFX_MAIL) ||
          has_pfx(PFX_RCPT) || has_pfx(PFX_DATA))) return APP_SMTP;
      if (on_port(s, d, PORT_SSH) && has_pfx(PFX_SSH)) return APP_SSH;
      if (on_port(s, d, PORT_SIP) && has_pfx(PFX_SIP)) return APP_SIP;
      return APP_NONE;
    endfunction

    function app_class_e udp_app(bit [15:0] s, bit [15:0] d);
      if (on_port(s, d, PORT_DNS)) return APP_DNS;
      if (on_port(s, d, PORT_DHCPS) || on_port(s, d, PORT_DHCPC)) return APP_DHCP;
      if (on_port(s, d, PORT_TFTP)) return APP_TFTP;
      if (on_port(s, d, PORT_SNMP)) return APP_SNMP;
      if (on_port(s, d, PORT_RIP)) return APP_RIP;
      return APP_NONE;
    endfunction

    function void absorb(int unsigned p, bit [7:0] b);
      int unsigned l4;
      int unsigned rel;
      int unsigned start;
      int unsigned k;
      bit [7:0]    proto;
      proto = cap[47:40];
      case (p)
        12: cap[63:56] = b;
        13: cap[55:48] = b;
        14: ihl_w = (b[3:0] < 4'd5) ? 4'd5 : b[3:0];
        23: cap[47:40] = b;
        default: ;
      endcase
      if (ihl_w == 0 || p < 24) return;
      l4 = 14 + ihl_w * 4;
      if (p < l4) return;
      rel = p - l4;
      case (rel)
        0: cap[39:32] = b;
        1: cap[31:24] = b;
        2: cap[23:16] = b;
        3: cap[15:8] = b;
        default: ;
      endcase
      if (proto == PROTO_TCP) begin
        if (rel == 12) tcp_w = (b[7:4] < 4'd5) ? 4'd5 : b[7:4];
        if (rel == 13) cap[7:0] = b;
        if (tcp_w == 0) return;
        start = tcp_w * 4;
      end else if (proto == PROTO_UDP) begin
        start = 8;
      end else begin
        return;
      end
      if (rel < start) return;
      k = rel - start;
      if (k == 0) first_pay = b;
      for (int i = 0; i < NUM_PREFIXES; i++) begin
        if (k < pfx_text[i].len() && pfx_text[i][k] != b) pfx_ok[i] = 1'b0;
      end
      if (pay_n < MAX_BYTES) pay_n++;
    endfunction

    function frame_verdict_t classify();
      frame_verdict_t v;
      int unsigned    n;
      int unsigned    l4;
      v.eth_type = '0;
      v.ether_class = ETH_CLASS_UNKNOWN;
      v.ipv4_proto = '0;
      v.protocol_known = 1'b0;
      v.l4_kind = L4_NONE;
      v.source_port = '0;
      v.dest_port = '0;
      v.tcp_flag_bits = '0;
      v.app_class = APP_NONE;
      v.truncated = 1'b0;
      n = offs;
      if (n >= 14) begin
        v.eth_type = cap[63:48];
        v.ether_class = ether_class_for(cap[63:48]);
      end
      if (n >= 24) begin
        v.ipv4_proto = cap[47:40];
        v.protocol_known = proto_named(cap[47:40]);
        v.l4_kind = (cap[47:40] == PROTO_TCP) ? L4_TCP :
                    (cap[47:40] == PROTO_UDP) ? L4_UDP : L4_NONE;
      end
      if (n < 15 || ihl_w == 0) begin
        v.truncated = 1'b1;
      end else begin
        l4 = 14 + ihl_w * 4;
        if (n < l4) v.truncated = 1'b1;
        if (v.l4_kind != L4_NONE && n >= l4 + 4) begin
          v.source_port = cap[39:24];
          v.dest_port = cap[23:8];
        end
        if (v.l4_kind == L4_TCP) begin
          if (n >= l4 + 14) v.tcp_flag_bits = cap[7:0];
          if (tcp_w == 0 || n < l4 + tcp_w * 4) v.truncated = 1'b1;
        end else if (v.l4_kind == L4_UDP) begin
          if (n < l4 + 8) v.truncated = 1'b1;
        end
      end
      if (pay_n > 0) begin
        if (v.l4_kind == L4_TCP) v.app_class = tcp_app(v.source_port, v.dest_port);
        else if (v.l4_kind == L4_UDP) v.app_class = udp_app(v.source_port, v.dest_port);
      end
      return v;
    endfunction

    function void take_frame_byte(bit [7:0] b, bit last);
      if (offs < MAX_BYTES) begin
        absorb(offs, b);
        offs++;
      end
      if (last) begin
        verdict_q.push_back(classify());
        clear();
      end
    endfunction

    function void cmp(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_frame_result(frame_verdict_t got);
      frame_verdict_t want;
      if (verdict_q.size() == 0) begin
        $error("frame result with no frame pending");
        errors++;
        return;
      end
      want = verdict_q.pop_front();
      cmp("eth_type", want.eth_type, got.eth_type);
      cmp("ether_class", want.ether_class, got.ether_class);
      cmp("ipv4_proto", want.ipv4_proto, got.ipv4_proto);
      cmp("protocol_known", want.protocol_known, got.protocol_known);
      cmp("l4_kind", want.l4_kind, got.l4_kind);
      cmp("source_port", want.source_port, got.source_port);
      cmp("dest_port", want.dest_port, got.dest_port);
      cmp("tcp_flag_bits", want.tcp_flag_bits, got.tcp_flag_bits);
      cmp("app_class", want.app_class, got.app_class);
      cmp("truncated", want.truncated, got.truncated);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  fhpc_in_if  in_if ();
  fhpc_out_if out_if ();

  frame_header_protocol_classifier_core #(
    .MAX_FRAME_BYTES(MAX_BYTES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  frame_verdict_board board;
  logic [7:0]         frame_q[$];
  int unsigned        pay_at;
  int unsigned        bytes_sent;
  int unsigned        tx_idle_pct;
  int unsigned        rx_stall_pct;
  int unsigned        rx_hold;
  int unsigned        cycles;

  logic [15:0] hot_ports[12] = '{PORT_FTP, PORT_SSH, PORT_SMTP, PORT_DNS, PORT_DHCPS, PORT_DHCPC,
                                 PORT_TFTP, PORT_HTTP, PORT_SNMP, PORT_HTTPS, PORT_RIP, PORT_SIP};
  logic [15:0] etypes[9] = '{ETYPE_IPV4, ETYPE_ARP, ETYPE_IPV6, ETYPE_X75, ETYPE_PUP,
                             ETYPE_RARP, ETYPE_MPLS_UNI, ETYPE_MPLS_MC, ETYPE_SPECIAL};

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    out_if.ready = 1'b0;
    rx_hold = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        rx_hold--;
        out_if.ready <= 1'b0;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        rx_hold = $urandom_range(0, 18);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    frame_verdict_t got;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.eth_type = out_if.eth_type;
      got.ether_class = ether_class_e'(out_if.ether_class);
      got.ipv4_proto = out_if.ipv4_proto;
      got.protocol_known = out_if.protocol_known;
      got.l4_kind = l4_kind_e'(out_if.l4_kind);
      got.source_port = out_if.source_port;
      got.dest_port = out_if.dest_port;
      got.tcp_flag_bits = out_if.tcp_flag_bits;
      got.app_class = app_class_e'(out_if.app_class);
      got.truncated = out_if.truncated;
      board.check_frame_result(got);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.frame_byte <= b;
    in_if.last_byte <= last;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    board.take_frame_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (board.verdict_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic noise_frame(input int unsigned len, input logic [15:0] et);
    frame_q.delete();
    repeat (len) frame_q.push_back(8'($urandom));
    if (len > 12) frame_q[12] = et[15:8];
    if (len > 13) frame_q[13] = et[7:0];
  endtask

  task automatic cut(input int unsigned n);
    while (frame_q.size() > n) void'(frame_q.pop_back());
  endtask

  task automatic build_frame(input logic [15:0] et, input logic [7:0] vihl,
                             input logic [7:0] proto, input logic [15:0] sp,
                             input logic [15:0] dp, input logic [3:0] doff,
                             input logic [7:0] flags, input string pay);
    int unsigned ihl_eff;
    int unsigned doff_eff;
    int unsigned l4;
    noise_frame(14, et);
    frame_q.push_back(vihl);
    repeat (8) frame_q.push_back(8'($urandom));
    frame_q.push_back(proto);
    ihl_eff = (vihl[3:0] < 4'd5) ? 5 : vihl[3:0];
    while (frame_q.size() < 14 + ihl_eff * 4) frame_q.push_back(8'($urandom));
    l4 = frame_q.size();
    frame_q.push_back(sp[15:8]);
    frame_q.push_back(sp[7:0]);
    frame_q.push_back(dp[15:8]);
    frame_q.push_back(dp[7:0]);
    if (proto == PROTO_TCP) begin
      repeat (8) frame_q.push_back(8'($urandom));
      frame_q.push_back({doff, 4'($urandom)});
      frame_q.push_back(flags);
      doff_eff = (doff < 4'd5) ? 5 : doff;
      while (frame_q.size() < l4 + doff_eff * 4) frame_q.push_back(8'($urandom));
    end else begin
      repeat (4) frame_q.push_back(8'($urandom));
    end
    pay_at = frame_q.size();
    for (int i = 0; i < pay.len(); i++) frame_q.push_back(pay[i]);
  endtask

  task automatic random_frame();
    int unsigned r;
    logic [15:0] et;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  proto;
    string       pay;
    et = ($urandom_range(0, 3) == 0) ? etypes[$urandom_range(0, 8)] : ETYPE_IPV4;
    if ($urandom_range(0, 5) == 0) et = 16'($urandom);
    if ($urandom_range(0, 99) < 12) begin
      noise_frame($urandom_range(1, 64), et);
      send_frame();
      return;
    end
    r = $urandom_range(0, 99);
    proto = (r < 45) ? PROTO_TCP : (r < 80) ? PROTO_UDP : 8'($urandom);
    sp = 16'($urandom);
    dp = 16'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 1) == 1) sp = hot_ports[$urandom_range(0, 11)];
      else dp = hot_ports[$urandom_range(0, 11)];
    end
    pay = ($urandom_range(0, 9) < 6) ? board.pfx_text[$urandom_range(0, NUM_PREFIXES - 1)] : "";
    if (pay.len() > 0 && $urandom_range(0, 3) == 0)
      pay = pay.substr(0, $urandom_range(0, pay.len() - 1));
    build_frame(et, {4'h4, ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5}, proto, sp, dp,
                ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5, 8'($urandom), pay);
    repeat ($urandom_range(0, 12)) frame_q.push_back(8'($urandom));
    if (frame_q.size() > pay_at && $urandom_range(0, 5) == 0) frame_q[pay_at] = TLS_HANDSHAKE;
    if (frame_q.size() > pay_at && $urandom_range(0, 7) == 0)
      frame_q[pay_at + $urandom_range(0, frame_q.size() - pay_at - 1)] = 8'($urandom);
    if ($urandom_range(0, 6) == 0) cut($urandom_range(1, frame_q.size()));
    send_frame();
  endtask

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 4;
      default: return 20;
    endcase
  endfunction

  initial begin
    int unsigned nframes;
    board = new();
    cycles = 0;
    bytes_sent = 0;
    pay_at = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.frame_byte = 8'h00;
    in_if.last_byte = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed frames
    tx_idle_pct = 10;
    rx_stall_pct = 10;
    for (int d = 0; d < 30; d++) begin
      case (d)
        0: noise_frame(1, 16'h0000);
        1: noise_frame(13, ETYPE_IPV4);
        2: begin
          build_frame(ETYPE_IPV4, 8'h45, PROTO_TCP, PORT_HTTP, 16'd1024, 4'd5, 8'h02, "GET");
          cut(14);
        end
        3: begin
          build_frame(ETYPE_ARP, 8'h45, 8'd33, 16'd1, 16'd2, 4'd5, 8'h00, "");
          cut(20);
        end
        4: build_frame(ETYPE_IPV6, 8'h40, 8'd254, 16'd1, 16'd2, 4'd5, 8'h00, "");
        5: build_frame(ETYPE_X75, 8'h4F, PROTO_TCP, PORT_HTTP, 16'd1234, 4'd5, 8'hFF, "GET /");
        6: begin
          build_frame(ETYPE_PUP, 8'h45, PROTO_TCP, PORT_HTTPS, 16'd5000, 4'd0, 8'h12, "ABCDEFGH");
          frame_q[pay_at] = TLS_HANDSHAKE;
        end
        7: begin
          build_frame(ETYPE_RARP, 8'h45, PROTO_TCP, 16'd6000, PORT_HTTPS, 4'd15, 8'h00, "ABCDE");
          frame_q[pay_at] = TLS_HANDSHAKE;
        end
        8: build_frame(ETYPE_MPLS_UNI, 8'h45, PROTO_TCP, PORT_FTP, 16'd3000, 4'd5, 8'h18,
                       "USER bob");
        9: build_frame(ETYPE_MPLS_MC, 8'h45, PROTO_TCP, 16'd40000, PORT_FTP, 4'd5, 8'h18,
                       "PASS x");
        10: build_frame(ETYPE_SPECIAL, 8'h45, PROTO_TCP, PORT_SMTP, 16'd7, 4'd5, 8'h18, "EHLO a");
        11: build_frame(16'h1234, 8'h45, PROTO_TCP, PORT_SMTP, 16'd7, 4'd5, 8'h18,
                        "MAIL FROM:<a>");
        12: build_frame(ETYPE_IPV4, 8'h45, PROTO_TCP, 16'd7, PORT_SMTP, 4'd5, 8'h18, "RCPT TO:b");
        13: build_frame(ETYPE_IPV4, 8'h45, PROTO_TCP, PORT_SMTP, 16'd7, 4'd5, 8'h18, "DATA");
        14: build_frame(ETYPE_IPV4, 8'h45, PROTO_TCP, PORT_SMTP, 16'd7, 4'd5, 8'h18, "HELO x");
        15: build_frame(ETYPE_IPV4, 8'h45, PROTO_TCP, PORT_SSH, 16'd7, 4'd5, 8'h18, "SSH-2.0");
        16: build_frame(ETYPE_IPV4, 8'h45, PROTO_TCP, 16'd7, PORT_SIP, 4'd5, 8'h18, "SIP/2.0");
        17: build_frame(ETYPE_IPV4, 8'h45, PROTO_TCP, PORT_SIP, 16'd7, 4'd5, 8'h18, "SI");
        18: build_frame(ETYPE_IPV4, 8'h45, PROTO_TCP, PORT_HTTP, 16'd7, 4'd5, 8'h10, "");
        19: build_frame(ETYPE_IPV4, 8'h45, PROTO_UDP, 16'd999, PORT_DNS, 4'd5, 8'h00, "q");
        20: build_frame(ETYPE_IPV4, 8'h45, PROTO_UDP, PORT_DHCPS, 16'd999, 4'd5, 8'h00, "d");
        21: build_frame(ETYPE_IPV4, 8'h45, PROTO_UDP, 16'd999, PORT_DHCPC, 4'd5, 8'h00, "d");
        22: build_frame(ETYPE_IPV4, 8'h45, PROTO_UDP, PORT_TFTP, 16'd999, 4'd5, 8'h00, "t");
        23: build_frame(ETYPE_IPV4, 8'h45, PROTO_UDP, 16'd999, PORT_SNMP, 4'd5, 8'h00, "s");
        24: build_frame(ETYPE_IPV4, 8'h45, PROTO_UDP, PORT_RIP, PORT_RIP, 4'd5, 8'h00, "r");
        25: build_frame(ETYPE_IPV4, 8'h45, 8'd255, 16'd9999, 16'd9998, 4'd5, 8'h00, "zz");
        26: build_frame(ETYPE_IPV4, 8'h45, PROTO_UDP, PORT_DNS, 16'd999, 4'd5, 8'h00, "");
        27: begin
          build_frame(ETYPE_IPV4, 8'h45, PROTO_TCP, PORT_HTTP, 16'd7, 4'd8, 8'hA5, "xyz");
          cut(50);
        end
        28: begin
          build_frame(ETYPE_IPV4, 8'h45, PROTO_UDP, PORT_DNS, 16'd7, 4'd5, 8'h00, "xyz");
          cut(40);
        end
        default: build_frame(ETYPE_IPV4, 8'h42, PROTO_TCP, 16'd7, PORT_HTTP, 4'd2, 8'h01, "a");
      endcase
      send_frame();
    end

    // overlong frames: one at the size limit, one past it
    tx_idle_pct = 0;
    for (int d = 0; d < 2; d++) begin
      build_frame(ETYPE_IPV4, 8'h45, PROTO_TCP, PORT_HTTP, 16'd7, 4'd5, 8'h18, "hello");
      while (frame_q.size() < MAX_BYTES + 5 * d) frame_q.push_back(8'($urandom));
      send_frame();
    end

    // random frames
    nframes = 0;
    while (bytes_sent < BYTE_TARGET || nframes < FRAME_TARGET) begin
      if (nframes % 3 == 0) begin
        tx_idle_pct = pick_pct();
        rx_stall_pct = pick_pct();
      end
      if (nframes == 3) wait_results_drained();
      random_frame();
      nframes++;
    end

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    repeat (3) random_frame();

    in_if.last_byte <= 1'b0;
    wait_results_drained();
    repeat (10) @(negedge clk_i);
    if (board.errors == 0 && board.verdict_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== frame_header_protocol_classifier_core.f =====
sv/fhpc_pkg.sv
sv/fhpc_in_if.sv
sv/fhpc_out_if.sv
sv/frame_header_protocol_classifier_core.sv
tb/tb_top.sv
